@@ hdl/hex_run_length_decoder_assert.svh @@
// assertion macros for the hex run-length decoder checker
`ifndef HEX_RUN_LENGTH_DECODER_ASSERT_SVH
`define HEX_RUN_LENGTH_DECODER_ASSERT_SVH

// same-cycle implication
`define HRLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hex_run_length_decoder: same-cycle check failed");

// next-cycle implication
`define HRLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hex_run_length_decoder: next-cycle check failed");

`endif

@@ hdl/hrld_pkg.sv @@
// ----------------------------------------------------------------------------
// hrld_pkg
// Shared constants, types and the hex digit decode for the run-length decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrld_pkg;

    localparam int CHAR_W       = 8;
    localparam int NIBBLE_W     = 4;
    localparam int VALUE_W      = 2 * NIBBLE_W;
    localparam int COUNT_W      = 32;
    localparam int COUNT_DIGITS = 8;
    localparam int DIGIT_CNT_W  = $clog2(COUNT_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_OPEN_BRACKET = 8'h5B;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } char_beat_t;

    typedef struct packed {
        logic                is_hex;
        logic [NIBBLE_W-1:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_digit_t d;
        d.is_hex = 1'b0;
        d.value  = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.is_hex = 1'b1;
            d.value  = c[NIBBLE_W-1:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            // 'a'/'A' has low nibble 1, so add 9 to land on 10
            d.is_hex = 1'b1;
            d.value  = c[NIBBLE_W-1:0] + NIBBLE_W'(9);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hdl/hrld_in_stage.sv @@
// ----------------------------------------------------------------------------
// hrld_in_stage
// Input register: holds one character beat until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrld_in_stage
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [hrld_pkg::CHAR_W-1:0] char_code,
    input  wire logic                        end_of_text,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    output hrld_pkg::char_beat_t             beat,
    output logic                             beat_valid,
    input  wire logic                        beat_take
);
    import hrld_pkg::*;

    logic       valid_reg;
    char_beat_t beat_reg;

    assign in_ready   = !valid_reg || beat_take;
    assign beat       = beat_reg;
    assign beat_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg.char_code   <= char_code;
            beat_reg.end_of_text <= end_of_text;
        end
    end

endmodule

`default_nettype wire

@@ hdl/hrld_parser.sv @@
// ----------------------------------------------------------------------------
// hrld_parser
// Parse state machine and result register: one character per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrld_parser
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  hrld_pkg::char_beat_t              beat,
    input  wire logic                         beat_valid,
    output logic                              beat_take,
    output logic [hrld_pkg::VALUE_W-1:0]      run_value,
    output logic [hrld_pkg::COUNT_W-1:0]      run_count,
    output logic                              text_ended,
    output logic                              out_valid,
    input  wire logic                         out_ready
);
    import hrld_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_PAIR,
        PH_COUNT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [NIBBLE_W-1:0]    nibble_reg, nibble_next;
    logic [VALUE_W-1:0]     pending_reg, pending_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [DIGIT_CNT_W-1:0] digits_reg, digits_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [COUNT_W-1:0]     run_count_reg, run_count_next;
    logic                   ended_reg, ended_next;

    hex_digit_t hd;
    logic       emit;

    assign beat_take  = beat_valid && (!out_valid_reg || out_ready);
    assign hd         = hex_decode(beat.char_code);

    assign run_value  = value_reg;
    assign run_count  = run_count_reg;
    assign text_ended = ended_reg;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        nibble_next    = nibble_reg;
        pending_next   = pending_reg;
        count_next     = count_reg;
        digits_next    = digits_reg;
        emit           = 1'b0;
        value_next     = value_reg;
        run_count_next = run_count_reg;
        ended_next     = ended_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                nibble_next = hd.is_hex ? hd.value : nibble_reg;
                phase_next  = hd.is_hex ? PH_HIGH : PH_IDLE;
            end
            PH_HIGH:
            begin
                if (hd.is_hex)
                begin
                    pending_next = {nibble_reg, hd.value};
                    phase_next   = PH_PAIR;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PAIR:
            begin
                if (beat.char_code == CHAR_OPEN_BRACKET)
                begin
                    count_next  = '0;
                    digits_next = '0;
                    phase_next  = PH_COUNT;
                end
                else
                begin
                    emit           = 1'b1;
                    value_next     = pending_reg;
                    run_count_next = COUNT_W'(1);
                    ended_next     = beat.end_of_text;
                    // the closing character is decoded afresh
                    nibble_next    = hd.is_hex ? hd.value : nibble_reg;
                    phase_next     = hd.is_hex ? PH_HIGH : PH_IDLE;
                end
            end
            PH_COUNT:
            begin
                if (hd.is_hex && (digits_reg < DIGIT_CNT_W'(COUNT_DIGITS)))
                begin
                    count_next  = {count_reg[COUNT_W-NIBBLE_W-1:0], hd.value};
                    digits_next = digits_reg + DIGIT_CNT_W'(1);
                end
                else
                begin
                    emit           = 1'b1;
                    value_next     = pending_reg;
                    run_count_next = count_reg;
                    ended_next     = beat.end_of_text;
                    phase_next     = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // flush a pending run on the last character, then clear the parse state
        if (beat.end_of_text)
        begin
            if (!emit && phase_next == PH_PAIR)
            begin
                emit           = 1'b1;
                value_next     = pending_next;
                run_count_next = COUNT_W'(1);
                ended_next     = 1'b1;
            end
            else if (!emit && phase_next == PH_COUNT)
            begin
                emit           = 1'b1;
                value_next     = pending_next;
                run_count_next = count_next;
                ended_next     = 1'b1;
            end
            phase_next   = PH_IDLE;
            nibble_next  = '0;
            pending_next = '0;
            count_next   = '0;
            digits_next  = '0;
        end

        if (beat_take)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            nibble_reg    <= '0;
            pending_reg   <= '0;
            count_reg     <= '0;
            digits_reg    <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            run_count_reg <= '0;
            ended_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (beat_take)
            begin
                phase_reg   <= phase_next;
                nibble_reg  <= nibble_next;
                pending_reg <= pending_next;
                count_reg   <= count_next;
                digits_reg  <= digits_next;
                if (emit)
                begin
                    value_reg     <= value_next;
                    run_count_reg <= run_count_next;
                    ended_reg     <= ended_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/hex_run_length_decoder.sv @@
// ----------------------------------------------------------------------------
// hex_run_length_decoder
// Decodes hex text runs ("hh" or "hh[cccccccc") into value/count beats.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// in      | in_valid, in_ready  | char_code[7:0], end_of_text
// out     | out_valid, out_ready| run_value[7:0], run_count[31:0], text_ended
//
// one character per cycle sustained while out_ready holds; a run is presented
// once the character that closes it has passed the input register and the
// parse step into the result register
// rst_n clears parse state and both valid flags asynchronously
// a stalled result blocks the parser; an empty input register still takes one
// more beat, then in_ready drops until out_ready returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hex_run_length_decoder
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [hrld_pkg::CHAR_W-1:0]  char_code,
    input  wire logic                         end_of_text,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    output logic [hrld_pkg::VALUE_W-1:0]      run_value,
    output logic [hrld_pkg::COUNT_W-1:0]      run_count,
    output logic                              text_ended,
    output logic                              out_valid,
    input  wire logic                         out_ready
);
    import hrld_pkg::*;

    char_beat_t beat;
    logic       beat_valid;
    logic       beat_take;

    hrld_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .beat        (beat),
        .beat_valid  (beat_valid),
        .beat_take   (beat_take)
    );

    hrld_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .beat_valid (beat_valid),
        .beat_take  (beat_take),
        .run_value  (run_value),
        .run_count  (run_count),
        .text_ended (text_ended),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

`default_nettype wire

@@ hdl/hrld_checker.sv @@
// ----------------------------------------------------------------------------
// hrld_checker
// Port-level checks for the hex run-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hex_run_length_decoder_assert.svh"

module hrld_checker
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [hrld_pkg::VALUE_W-1:0] run_value,
    input  wire logic [hrld_pkg::COUNT_W-1:0] run_count,
    input  wire logic                         text_ended,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready
);
    import hrld_pkg::*;

    // a result beat is held until taken
    `HRLD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // stalled result payload does not move
    `HRLD_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
        $stable(run_value) && $stable(run_count) && $stable(text_ended))

    // with no result waiting the input side is always open
    `HRLD_ASSERT_IMP(a_in_open, clk, rst_n, !out_valid, in_ready)

    // a beat taken under a stalled result fills the input register
    `HRLD_ASSERT_NXT(a_backpressure, clk, rst_n,
        out_valid && !out_ready && in_valid && in_ready, out_ready || !in_ready)

endmodule

bind hex_run_length_decoder hrld_checker u_hrld_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .run_value  (run_value),
    .run_count  (run_count),
    .text_ended (text_ended),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
);

`default_nettype wire
